/* hw/rtl/pdwa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdwa_pkg
// Shared types and constants for the priority dispatcher with aging.
// ----------------------------------------------------------------------------
package pdwa_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = 5;
  localparam int STAMP_W     = 16;
  localparam logic [7:0] AGING_RESET = 8'd10;
  localparam logic [7:0] WAIT_MAX    = 8'hFF;

  typedef enum logic [1:0] {
    OP_ADMIT  = 2'd0,
    OP_TICK   = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0]         tid;
    logic [7:0]         prio;
    logic [7:0]         wait_cnt;
    logic               promoted;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

endpackage

/* hw/rtl/priority_dispatch_with_aging_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_dispatch_with_aging_core
// Non-preemptive priority dispatcher with aging over a table of waiting tasks.
// Flow: an accepted beat walks the slot table in ST_SCAN, passes ST_DRAIN,
//   and ST_FINISH registers the result beat; in_stall holds off new beats
//   until ST_IDLE; the single table read port is walked one entry per cycle.
// Reset: clears slot valid bits, busy flag, admission counter, ready count and
//   loads the aging threshold with 10; the slot table contents are not cleared.
// ----------------------------------------------------------------------------
module priority_dispatch_with_aging_core
  import pdwa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [7:0]        in_task_id,
  input  logic [7:0]        in_task_priority,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_dispatched,
  output logic [7:0]        out_dispatched_id,
  output logic [7:0]        out_dispatched_priority,
  output logic              out_from_promoted,
  output logic              out_running,
  output logic [CNT_W-1:0]  out_ready_count,
  output logic              out_admit_rejected
);

  // slot table
  slot_t mem [SLOTS];
  slot_t mem_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [SLOT_W-1:0] mem_raddr;
  slot_t             mem_wdata;

  state_t state_r, state_nxt;

  logic [7:0]         thr_r;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic               busy_r, busy_nxt;
  logic [STAMP_W-1:0] adm_cnt_r, adm_cnt_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [1:0]         op_r;
  logic               rejected_r;

  logic [SLOT_W-1:0]  idx_r;
  logic               rd_pend_r;
  logic [SLOT_W-1:0]  rd_idx_r;

  logic               best_valid_r;
  logic [SLOT_W-1:0]  best_idx_r;
  logic               best_prom_r;
  logic [7:0]         best_prio_r;
  logic [7:0]         best_tid_r;
  logic [STAMP_W-1:0] best_age_r;

  logic               out_valid_r;
  logic               out_disp_r;
  logic [7:0]         out_id_r;
  logic [7:0]         out_prio_r;
  logic               out_prom_r;
  logic               out_run_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_rej_r;

  logic               in_accept;
  logic               full;
  logic [SLOT_W-1:0]  free_idx;
  logic               admit_go;
  logic               scan_last;
  logic               proc_en;
  logic [7:0]         new_wait;
  logic               new_prom;
  slot_t              wb;
  logic [STAMP_W-1:0] cand_age;
  logic               cand_better;
  logic               out_free;
  logic               finish_go;
  logic               disp_fire;

  // control outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    mem_raddr = idx_r;
    out_free  = !out_valid_r || !out_stall;
    finish_go = (state_r == ST_FINISH) && out_free;
    disp_fire = finish_go && !busy_r && best_valid_r;
  end

  assign in_accept = in_valid && (state_r == ST_IDLE);
  assign scan_last = (idx_r == SLOT_W'(SLOTS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_accept) state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SLOT_W'(i);
        full     = 1'b0;
      end
    end
  end

  assign admit_go = in_accept && (in_operation == OP_ADMIT) && !full;

  // aging, promotion and candidate compare on the read beat
  always_comb begin
    proc_en  = rd_pend_r && valid_r[rd_idx_r];
    new_wait = ((op_r == OP_TICK) && (mem_q.wait_cnt != WAIT_MAX)) ?
               mem_q.wait_cnt + 8'd1 : mem_q.wait_cnt;
    new_prom = mem_q.promoted || (new_wait >= thr_r);
    wb          = mem_q;
    wb.wait_cnt = new_wait;
    wb.promoted = new_prom;
    cand_age = adm_cnt_r - mem_q.stamp;
    if (new_prom != best_prom_r) begin
      cand_better = new_prom;
    end else if (mem_q.prio != best_prio_r) begin
      cand_better = (mem_q.prio < best_prio_r);
    end else begin
      cand_better = (cand_age > best_age_r);
    end
  end

  // table write port
  always_comb begin
    mem_we    = admit_go || proc_en;
    mem_waddr = rd_idx_r;
    mem_wdata = wb;
    if (admit_go) begin
      mem_waddr          = free_idx;
      mem_wdata.tid      = in_task_id;
      mem_wdata.prio     = in_task_priority;
      mem_wdata.wait_cnt = '0;
      mem_wdata.promoted = 1'b0;
      mem_wdata.stamp    = adm_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  // state updates
  always_comb begin
    valid_nxt   = valid_r;
    busy_nxt    = busy_r;
    adm_cnt_nxt = adm_cnt_r;
    count_nxt   = count_r;
    if (admit_go) begin
      valid_nxt[free_idx] = 1'b1;
      adm_cnt_nxt         = adm_cnt_r + STAMP_W'(1);
      count_nxt           = count_r + CNT_W'(1);
    end
    if (in_accept && (in_operation == OP_FINISH)) begin
      busy_nxt = 1'b0;
    end
    if (disp_fire) begin
      valid_nxt[best_idx_r] = 1'b0;
      busy_nxt              = 1'b1;
      count_nxt             = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      thr_r     <= AGING_RESET;
      valid_r   <= '0;
      busy_r    <= 1'b0;
      adm_cnt_r <= '0;
      count_r   <= '0;
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
      best_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      busy_r    <= busy_nxt;
      adm_cnt_r <= adm_cnt_nxt;
      count_r   <= count_nxt;
      rd_pend_r <= (state_r == ST_SCAN);
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (in_accept) begin
        idx_r <= '0;
      end else if (state_r == ST_SCAN) begin
        idx_r <= idx_r + SLOT_W'(1);
      end
      if (in_accept) begin
        best_valid_r <= 1'b0;
      end else if (proc_en && (!best_valid_r || cand_better)) begin
        best_valid_r <= 1'b1;
      end
      if (finish_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    if (in_accept) begin
      op_r       <= in_operation;
      rejected_r <= (in_operation == OP_ADMIT) && full;
    end
    if (proc_en && (!best_valid_r || cand_better)) begin
      best_idx_r  <= rd_idx_r;
      best_prom_r <= new_prom;
      best_prio_r <= mem_q.prio;
      best_tid_r  <= mem_q.tid;
      best_age_r  <= cand_age;
    end
    if (finish_go) begin
      out_disp_r  <= disp_fire;
      out_id_r    <= disp_fire ? best_tid_r : 8'd0;
      out_prio_r  <= disp_fire ? best_prio_r : 8'd0;
      out_prom_r  <= disp_fire && best_prom_r;
      out_run_r   <= busy_nxt;
      out_count_r <= count_nxt;
      out_rej_r   <= rejected_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_dispatched          = out_disp_r;
  assign out_dispatched_id       = out_id_r;
  assign out_dispatched_priority = out_prio_r;
  assign out_from_promoted       = out_prom_r;
  assign out_running             = out_run_r;
  assign out_ready_count         = out_count_r;
  assign out_admit_rejected      = out_rej_r;

  // checks
  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_r)))
    else $error("ready count out of step with valid bits");

  a_dispatch_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
    disp_fire |-> valid_r[best_idx_r])
    else $error("dispatch from an empty slot");

  a_dispatch_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    disp_fire |=> busy_r && out_valid_r && out_disp_r)
    else $error("dispatch did not mark the task running");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result beat raised outside finish");

endmodule
